[hw/rtl/gstg_pkg.sv]
// gstg_pkg: shared types, constants and helpers of the gated square tone generator
// no dependencies
`default_nettype none

package gstg_pkg;

  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned DUR_W    = 24;
  localparam int unsigned RATE_W   = 17;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned PHASE_W  = 24;
  localparam int unsigned FRAMES_W = 21;
  localparam int unsigned DIVD_W   = 41;
  localparam int unsigned QUOT_W   = 22;
  localparam int unsigned QH_W     = 5;

  localparam int unsigned CMD_LOAD = 0;
  localparam int unsigned CMD_TICK = 1;

  localparam int unsigned REG_SAMPLE_RATE = 0;
  localparam int unsigned REG_VOLUME      = 1;

  localparam int unsigned RATE_RESET   = 8000;
  localparam int unsigned VOLUME_RESET = 35;

  localparam int unsigned GATE_PERCENT  = 88;
  localparam int unsigned ROUND_HALF_US = 500000;
  localparam int unsigned US_PER_SECOND = 1000000;
  localparam int unsigned PERCENT_FULL  = 100;
  localparam int unsigned FRAMES_MAX    = 2097151;

  // x/1e6 = (x >> 6)/15625, the odd part split at bit 17 into two reciprocal steps
  localparam int unsigned DIV_PRESHIFT = 6;
  localparam int unsigned DIV_SPLIT    = 17;
  localparam int unsigned DIV_ODD      = 15625;
  localparam int unsigned DIV_REM_W    = 14;
  localparam int unsigned DIV_HI_MUL   = 274878;
  localparam int unsigned DIV_HI_MUL_W = 19;
  localparam int unsigned DIV_HI_SHIFT = 32;
  localparam int unsigned DIV_LO_MUL   = 32'd2251799814;
  localparam int unsigned DIV_LO_MUL_W = 32;
  localparam int unsigned DIV_LO_SHIFT = 45;

  // 88*n/100 = 22*n/25 via reciprocal 59055801/2^26, exact for 21-bit n
  localparam int unsigned GATE_MUL   = 59055801;
  localparam int unsigned GATE_MUL_W = 26;
  localparam int unsigned GATE_SHIFT = 26;

  // 32767*v/100 = 327*v + floor(67*v/100), the fraction via reciprocal 5243/2^19
  localparam int unsigned AMP_INT_MUL    = 327;
  localparam int unsigned AMP_FRAC_MUL   = 351281;
  localparam int unsigned AMP_FRAC_SHIFT = 19;

  localparam int unsigned FRONT_DEPTH = 2;

  typedef struct packed {
    logic              tick;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                tone_last;
    logic                gate_on;
  } result_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [PHASE_W-1:0] wrap;
    logic [AMP_W-1:0]   amp;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [AMP_W-1:0] amp_of(input logic [VOL_W-1:0] vol);
    logic [VOL_W-1:0] v;
    logic [25:0]      frac;
    v    = (vol > VOL_W'(PERCENT_FULL)) ? VOL_W'(PERCENT_FULL) : vol;
    frac = 26'(v) * 26'(AMP_FRAC_MUL);
    return AMP_W'(AMP_W'(v) * AMP_W'(AMP_INT_MUL) + AMP_W'(frac >> AMP_FRAC_SHIFT));
  endfunction

  function automatic logic [PHASE_W-1:0] wrap_of(input logic [RATE_W-1:0] rate);
    return PHASE_W'(PHASE_W'(rate) * PHASE_W'(PERCENT_FULL));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gstg_div.sv]
// gstg_div: divide by one million through reciprocal multiplication, three registered steps
// depends on gstg_pkg
`default_nettype none

module gstg_div import gstg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int unsigned Y_W       = DIVD_W - DIV_PRESHIFT;
  localparam int unsigned YH_W      = Y_W - DIV_SPLIT;
  localparam int unsigned HI_PROD_W = YH_W + DIV_HI_MUL_W;
  localparam int unsigned LO_W      = DIV_REM_W + DIV_SPLIT;
  localparam int unsigned LO_PROD_W = LO_W + DIV_LO_MUL_W;

  logic [Y_W-1:0]       y;
  logic [QH_W-1:0]      q_hi;
  logic [LO_W-1:0]      lo_num;
  logic [QUOT_W-1:0]    quotient;
  logic [3:0]           stage;
  logic [YH_W-1:0]      y_hi;
  logic [DIV_SPLIT-1:0] y_lo;
  logic [HI_PROD_W-1:0] hi_prod;
  logic [DIV_REM_W-1:0] rem_hi;
  logic [LO_PROD_W-1:0] lo_prod;

  assign y_hi    = y[Y_W-1:DIV_SPLIT];
  assign y_lo    = y[DIV_SPLIT-1:0];
  // upper part over 15625, exact below 2^18
  assign hi_prod = HI_PROD_W'(y_hi) * HI_PROD_W'(DIV_HI_MUL);
  assign rem_hi  = DIV_REM_W'(y_hi - YH_W'(q_hi) * YH_W'(DIV_ODD));
  // remainder joined with the lower part over 15625, exact below 2^31
  assign lo_prod = LO_PROD_W'(lo_num) * LO_PROD_W'(DIV_LO_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[2:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      y <= req.dividend[DIVD_W-1:DIV_PRESHIFT];
    end
    if (stage[0]) begin
      q_hi <= hi_prod[DIV_HI_SHIFT +: QH_W];
    end
    if (stage[1]) begin
      lo_num <= {rem_hi, y_lo};
    end
    if (stage[2]) begin
      quotient <= {q_hi, lo_prod[DIV_LO_SHIFT +: DIV_SPLIT]};
    end
  end

  assign rsp.done     = stage[3];
  assign rsp.quotient = quotient;

endmodule

`default_nettype wire

[hw/rtl/gstg_front.sv]
// gstg_front: input queue, takes pushed items and classifies them as load or tick
// depends on gstg_pkg
`default_nettype none

module gstg_front import gstg_pkg::*; #(
  parameter int unsigned DEPTH = FRONT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              command,
  input  wire logic [FREQ_W-1:0] tone_frequency,
  input  wire logic [DUR_W-1:0]  tone_duration_us,
  output logic                   item_valid,
  output item_t                  item,
  input  wire logic              item_pop
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  item_t              slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;
  item_t              incoming;

  assign full       = (count == COUNT_W'(DEPTH));
  assign item_valid = (count != '0);
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;
  assign item       = slots[rd_ptr];

  // classify the command into the queued item
  assign incoming.tick = (command == 1'(CMD_TICK));
  assign incoming.freq = tone_frequency;
  assign incoming.dur  = tone_duration_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gstg_back.sv]
// gstg_back: tone state, load sequencer and per-tick sample generation with result register
// depends on gstg_pkg, drives gstg_div through div_req_t / div_rsp_t
`default_nettype none

module gstg_back import gstg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire item_t    item,
  output logic          item_pop,
  input  wire cfg_t     cfg,
  output div_req_t      div_req,
  input  wire div_rsp_t div_rsp,
  output logic          res_valid,
  output result_t       res,
  input  wire logic     res_pop,
  output logic          busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_GMUL = 3'd3;

  localparam int unsigned GPROD_W = FRAMES_W + GATE_MUL_W;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [PHASE_W-1:0]  phase_acc;
  logic [FRAMES_W-1:0] frames_left;
  logic [FRAMES_W-1:0] gate_frames_left;
  logic [FREQ_W-1:0]   step_value;
  logic [DUR_W-1:0]    dur;

  logic                slot_free;
  logic                do_tick;
  logic                do_load;
  logic                gate;
  logic [PHASE_W:0]    p_sum;
  logic [PHASE_W:0]    p_once;
  logic [PHASE_W-1:0]  phase_next;
  logic [SAMPLE_W-1:0] amp_word;
  logic [SAMPLE_W-1:0] sample_next;
  logic [FRAMES_W-1:0] frames_sat;
  logic [GPROD_W-1:0]  gate_prod;

  assign busy      = (state != S_IDLE);
  assign slot_free = !res_valid || res_pop;
  assign do_tick   = (state == S_IDLE) && item_valid && item.tick &&
                     (frames_left != '0) && slot_free;
  assign do_load   = (state == S_IDLE) && item_valid && !item.tick;
  assign item_pop  = (state == S_IDLE) && item_valid &&
                     (!item.tick || frames_left == '0 || slot_free);

  assign gate   = (gate_frames_left != '0);
  assign p_sum  = {1'b0, phase_acc} + (PHASE_W + 1)'(step_value);
  assign p_once = (p_sum >= {1'b0, cfg.wrap}) ? p_sum - {1'b0, cfg.wrap} : p_sum;
  always_comb begin
    if (cfg.wrap == '0 || p_once >= {1'b0, cfg.wrap}) begin
      phase_next = '0;
    end else begin
      phase_next = PHASE_W'(p_once);
    end
  end

  assign amp_word = SAMPLE_W'(cfg.amp);
  always_comb begin
    if (!gate) begin
      sample_next = '0;
    end else if (phase_acc < (cfg.wrap >> 1)) begin
      sample_next = amp_word;
    end else begin
      sample_next = SAMPLE_W'(-amp_word);
    end
  end

  always_comb begin
    if (div_rsp.quotient > QUOT_W'(FRAMES_MAX)) begin
      frames_sat = FRAMES_W'(FRAMES_MAX);
    end else if (div_rsp.quotient == '0) begin
      frames_sat = FRAMES_W'(1);
    end else begin
      frames_sat = FRAMES_W'(div_rsp.quotient);
    end
  end

  assign gate_prod = GPROD_W'(frames_left) * GPROD_W'(GATE_MUL);

  always_comb begin
    div_req          = '0;
    div_req.dividend = DIVD_W'(DIVD_W'(dur) * DIVD_W'(cfg.rate) + DIVD_W'(ROUND_HALF_US));
    state_next       = state;
    case (state)
      S_IDLE: begin
        if (do_load) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        div_req.start = 1'b1;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_next = (step_value == '0) ? S_IDLE : S_GMUL;
        end
      end
      S_GMUL: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase_acc        <= '0;
      frames_left      <= '0;
      gate_frames_left <= '0;
      step_value       <= '0;
      res_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (do_tick) begin
        res_valid   <= 1'b1;
        frames_left <= frames_left - 1'b1;
        if (gate) begin
          phase_acc        <= phase_next;
          gate_frames_left <= gate_frames_left - 1'b1;
        end
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      if (do_load) begin
        phase_acc  <= '0;
        step_value <= item.freq;
      end
      if (state == S_DIV1 && div_rsp.done) begin
        frames_left      <= frames_sat;
        gate_frames_left <= '0;
      end
      if (state == S_GMUL) begin
        gate_frames_left <= gate_prod[GATE_SHIFT +: FRAMES_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      dur <= item.dur;
    end
    if (do_tick) begin
      res.sample    <= sample_next;
      res.tone_last <= (frames_left == FRAMES_W'(1));
      res.gate_on   <= gate;
    end
  end

  a_gate_within_tone: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (gate_frames_left <= frames_left))
    else $error("gate count exceeds frame count");

  a_silent_is_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.gate_on) |-> (res.sample == '0))
    else $error("silent item carries a nonzero sample");

  a_result_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_IDLE))
    else $error("result produced outside idle state");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !item_pop)
    else $error("item taken while load in progress");

endmodule

`default_nettype wire

[hw/rtl/gated_square_tone_generator.sv]
// Gated square tone generator. A tick item (command 1) yields one sample while frames of
// the current tone remain, waiting for a free output register, and nothing once the tone
// has run out. A load item (command 0) yields nothing and holds the back end busy: its
// frame count goes through a three-step reciprocal divide by one million, the sounded-frame
// count is then formed in a multiply state, skipped for a rest; ticks queued behind it wait.
// Items are taken into a small input queue meanwhile; a finished sample sits in an output
// register until popped.
// Configuration writes are held off (cfg_ready low) while any item is queued or a load
// is running, so rate and volume changes land between items.
`default_nettype none

module gated_square_tone_generator import gstg_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = FRONT_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                command,
  input  wire logic [FREQ_W-1:0]   tone_frequency,
  input  wire logic [DUR_W-1:0]    tone_duration_us,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                     tone_last,
  output logic                     gate_on,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [RATE_W-1:0]   cfg_data
);

  logic              item_valid;
  item_t             item;
  logic              item_pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              res_valid;
  result_t           res;
  logic              busy;
  cfg_t              cfg;
  logic [RATE_W-1:0] sample_rate;
  logic [PHASE_W-1:0] wrap;
  logic [AMP_W-1:0]  amp;
  logic              cfg_write;

  assign cfg_ready = !busy && !item_valid;
  assign cfg_write = cfg_valid && cfg_ready;

  // wrap and amplitude are kept alongside the raw sample rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= RATE_W'(RATE_RESET);
      wrap        <= wrap_of(RATE_W'(RATE_RESET));
      amp         <= amp_of(VOL_W'(VOLUME_RESET));
    end else if (cfg_write) begin
      case (cfg_index)
        1'(REG_SAMPLE_RATE): begin
          sample_rate <= cfg_data;
          wrap        <= wrap_of(cfg_data);
        end
        1'(REG_VOLUME): begin
          amp <= amp_of(cfg_data[VOL_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.rate = sample_rate;
  assign cfg.wrap = wrap;
  assign cfg.amp  = amp;

  gstg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .command          (command),
    .tone_frequency   (tone_frequency),
    .tone_duration_us (tone_duration_us),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop)
  );

  gstg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gstg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .cfg        (cfg),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop),
    .busy       (busy)
  );

  assign empty     = !res_valid;
  assign sample    = res.sample;
  assign tone_last = res.tone_last;
  assign gate_on   = res.gate_on;

endmodule

`default_nettype wire

[test/tb_gated_square_tone_generator.sv]
`timescale 1ns / 1ps
// tb_gated_square_tone_generator: self-checking bench for the gated square tone generator
// directed table then random load/tick sequences, every sample predicted and checked in order
// depends on gstg_pkg and gated_square_tone_generator

module tb_gated_square_tone_generator;
  import gstg_pkg::*;

  localparam int unsigned FULL_SCALE    = 32767;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PHASE_ITEMS   = 350;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic              cmd;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic              reg_idx;
    logic [RATE_W-1:0] reg_val;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic command = 1'b0;
  logic [FREQ_W-1:0] tone_frequency = '0;
  logic [DUR_W-1:0] tone_duration_us = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [RATE_W-1:0] cfg_data = '0;
  logic full;
  logic empty;
  logic signed [SAMPLE_W-1:0] sample;
  logic tone_last;
  logic gate_on;
  logic cfg_ready;

  // tone state as the generator should hold it
  logic [RATE_W-1:0] rate_now;
  logic [VOL_W-1:0] volume_now;
  logic [PHASE_W-1:0] phase_now;
  logic [FRAMES_W-1:0] frames_now;
  logic [FRAMES_W-1:0] sounded_now;
  logic [FREQ_W-1:0] step_now;

  result_t pending_samples[$];
  result_t head_sample;
  stim_row_t directed_rows[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  gated_square_tone_generator uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .command(command),
    .tone_frequency(tone_frequency),
    .tone_duration_us(tone_duration_us),
    .empty(empty),
    .pop(pop),
    .sample(sample),
    .tone_last(tone_last),
    .gate_on(gate_on),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_gated_square_tone_generator: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic void apply_register(input logic idx, input logic [RATE_W-1:0] val);
    if (idx == 1'(REG_SAMPLE_RATE)) rate_now = val;
    else volume_now = val[VOL_W-1:0];
  endfunction

  function automatic bit tone_sample(input logic cmd, input logic [FREQ_W-1:0] freq,
                                     input logic [DUR_W-1:0] dur, output result_t res);
    longint unsigned frames;
    int unsigned wrap;
    int unsigned vol;
    int unsigned amp;
    int unsigned next_phase;
    res = '0;
    if (cmd == 1'(CMD_LOAD)) begin
      frames = (64'(dur) * 64'(rate_now) + ROUND_HALF_US) / US_PER_SECOND;
      if (frames == 0) frames = 1;
      if (frames > FRAMES_MAX) frames = FRAMES_MAX;
      frames_now = FRAMES_W'(frames);
      sounded_now = (freq == 0) ? '0 : FRAMES_W'(frames * GATE_PERCENT / PERCENT_FULL);
      step_now = freq;
      phase_now = '0;
      return 1'b0;
    end
    if (frames_now == 0) return 1'b0;
    wrap = 32'(rate_now) * PERCENT_FULL;
    vol = (volume_now > PERCENT_FULL) ? PERCENT_FULL : 32'(volume_now);
    amp = FULL_SCALE * vol / PERCENT_FULL;
    if (sounded_now != 0) begin
      res.gate_on = 1'b1;
      res.sample = (phase_now < wrap / 2) ? SAMPLE_W'(amp) : SAMPLE_W'(32'h10000 - amp);
      if (wrap == 0) begin
        phase_now = '0;
      end else begin
        next_phase = 32'(phase_now) + 32'(step_now);
        if (next_phase >= wrap) next_phase -= wrap;
        if (next_phase >= wrap) next_phase = 0;
        phase_now = PHASE_W'(next_phase);
      end
      sounded_now--;
    end
    res.tone_last = (frames_now == 1);
    frames_now--;
    return 1'b1;
  endfunction

  function automatic void add_item(input logic cmd, input logic [FREQ_W-1:0] freq,
                                   input logic [DUR_W-1:0] dur);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.freq = freq;
    row.dur = dur;
    row.reg_idx = 1'b0;
    row.reg_val = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_tick_want(input logic signed [SAMPLE_W-1:0] smp,
                                        input logic last, input logic gate);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.cmd = 1'(CMD_TICK);
    row.freq = '0;
    row.dur = '0;
    row.reg_idx = 1'b0;
    row.reg_val = '0;
    row.typed = 1'b1;
    row.want.sample = smp;
    row.want.tone_last = last;
    row.want.gate_on = gate;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(input logic idx, input logic [RATE_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_REG;
    row.cmd = 1'b0;
    row.freq = '0;
    row.dur = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(input logic cmd, input logic [FREQ_W-1:0] freq,
                           input logic [DUR_W-1:0] dur, input bit typed, input result_t want,
                           output bit produced);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    tone_frequency <= freq;
    tone_duration_us <= dur;
    @(posedge clk);
    while (full) @(posedge clk);
    produced = tone_sample(cmd, freq, dur, res);
    if (typed) pending_samples.push_back(want);
    else if (produced) pending_samples.push_back(res);
  endtask

  task automatic write_reg(input logic idx, input logic [RATE_W-1:0] val);
    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected sample", $signed(sample), 0);
        end else begin
          head_sample = pending_samples.pop_front();
          if (sample !== head_sample.sample)
            report_mismatch("sample", $signed(sample), $signed(head_sample.sample));
          if (tone_last !== head_sample.tone_last)
            report_mismatch("tone_last", tone_last, head_sample.tone_last);
          if (gate_on !== head_sample.gate_on)
            report_mismatch("gate_on", gate_on, head_sample.gate_on);
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    stim_row_t row;
    bit produced;
    int unsigned counted;
    int unsigned frames_target;
    int unsigned ticks;
    int unsigned period;
    int unsigned pick;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0] dur;
    int unsigned phase_rate[4];
    int unsigned phase_vol[4];
    int unsigned phase_send[4];
    int unsigned phase_recv[4];

    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_LOAD), '0, '0);
    add_tick_want(16'sd0, 1'b1, 1'b0);
    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_LOAD), 20'd100000, 24'd1000);
    add_tick_want(16'sd11468, 1'b0, 1'b1);
    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_TICK), '1, '1);
    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_LOAD), 20'hFFFFF, 24'hFFFFFF);
    add_tick_want(16'sd11468, 1'b0, 1'b1);
    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_TICK), '0, '0);
    add_reg(1'(REG_VOLUME), 17'd127);
    add_reg(1'(REG_SAMPLE_RATE), 17'd96000);
    add_item(1'(CMD_LOAD), 20'd799999, 24'hFFFFFF);
    add_tick_want(16'sd32767, 1'b0, 1'b1);
    add_item(1'(CMD_TICK), '0, '0);
    // rate of zero mid-tone
    add_reg(1'(REG_SAMPLE_RATE), 17'd0);
    add_tick_want(-16'sd32767, 1'b0, 1'b1);
    // step far above the wrap
    add_reg(1'(REG_SAMPLE_RATE), 17'd1000);
    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_TICK), '0, '0);
    add_reg(1'(REG_SAMPLE_RATE), 17'h1FFFF);
    add_reg(1'(REG_VOLUME), 17'd0);
    add_item(1'(CMD_LOAD), 20'd5, 24'hFFFFFF);
    add_tick_want(16'sd0, 1'b0, 1'b1);
    add_item(1'(CMD_TICK), '0, '0);
    add_item(1'(CMD_LOAD), 20'd799999, 24'd3);
    add_tick_want(16'sd0, 1'b1, 1'b0);
    add_item(1'(CMD_TICK), '0, '0);

    phase_rate[0] = 44100;
    phase_rate[1] = 96000;
    phase_rate[2] = 8000;
    phase_rate[3] = $urandom_range(8000, 96000);
    phase_vol[0] = 100;
    phase_vol[1] = 73;
    phase_vol[2] = 35;
    phase_vol[3] = $urandom_range(0, 127);
    phase_send[0] = 0;
    phase_send[1] = 57;
    phase_send[2] = 0;
    phase_send[3] = 15;
    phase_recv[0] = 0;
    phase_recv[1] = 0;
    phase_recv[2] = 57;
    phase_recv[3] = 15;

    rate_now = RATE_W'(RATE_RESET);
    volume_now = VOL_W'(VOLUME_RESET);
    phase_now = '0;
    frames_now = '0;
    sounded_now = '0;
    step_now = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) write_reg(row.reg_idx, row.reg_val);
      else send_item(row.cmd, row.freq, row.dur, row.typed, row.want, produced);
    end

    for (int p = 0; p < 4; p++) begin
      write_reg(1'(REG_SAMPLE_RATE), RATE_W'(phase_rate[p]));
      write_reg(1'(REG_VOLUME), RATE_W'(phase_vol[p]));
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        frames_target = $urandom_range(0, 40);
        period = US_PER_SECOND / rate_now;
        pick = $urandom_range(99);
        if (pick < 10) freq = '0;
        else if (pick < 20) freq = FREQ_W'($urandom());
        else freq = FREQ_W'($urandom_range(1, 799999));
        if ($urandom_range(99) < 5) dur = DUR_W'($urandom());
        else dur = DUR_W'(frames_target * period + $urandom_range(0, period));
        send_item(1'(CMD_LOAD), freq, dur, 1'b0, '0, produced);
        counted++;
        ticks = $urandom_range(0, frames_target + 4);
        repeat (ticks) begin
          send_item(1'(CMD_TICK), FREQ_W'($urandom()), DUR_W'($urandom()), 1'b0, '0, produced);
          if (produced) counted++;
        end
      end
    end

    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_gated_square_tone_generator: clean");
    end else begin
      $display("tb_gated_square_tone_generator: errors");
    end
    $finish;
  end

endmodule
